/* rtl/checksum_filtered_priority_packet_queue_macros.svh */
// Assertion macros used by the packet queue output side.
`ifndef CHECKSUM_FILTERED_PRIORITY_PACKET_QUEUE_MACROS_SVH
`define CHECKSUM_FILTERED_PRIORITY_PACKET_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CFPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CFPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cfpq_pkg.sv */
// Shared types and codes of the checksum filtered priority packet queue.
package cfpq_pkg;

    typedef enum logic [1:0] {
        CMD_HEADER  = 2'd0,
        CMD_DATA    = 2'd1,
        CMD_TRAILER = 2'd2,
        CMD_POP     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_BAD_SUM  = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_FULL     = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    // Slot numbers cover the largest supported queue depth (two queues of 256).
    localparam int SLOT_W = 9;

    typedef struct packed {
        logic [31:0] arrival_time;
        logic [7:0]  dest_addr;
        logic [7:0]  src_addr;
        logic [7:0]  priority_level;
        logic [6:0]  payload_length;
    } header_t;

    typedef enum logic {
        JOB_STATUS = 1'b0,
        JOB_STREAM = 1'b1
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        status_t            status;
        logic [SLOT_W-1:0]  slot;
    } job_t;

    typedef struct packed {
        logic               hdr_we;
        header_t            hdr;
        logic               pay_we;
        logic [7:0]         pay_byte;
        logic [6:0]         pay_idx;
        logic [SLOT_W-1:0]  slot;
    } store_wr_t;

endpackage

/* rtl/checksum_filtered_priority_packet_queue.sv */
// Top level of the checksum filtered priority packet queue.
// Usage: the input channel is a queue push port. A word is taken at a rising
// edge with push high and full low. Command header opens a packet, data
// words add bytes, the trailer closes it with its XOR checksum, and pop asks
// for the oldest packet of the low (pop_queue 0) or high (pop_queue 1) queue.
// Header, data and stray trailer words give no result. A trailer that
// closes a packet gives one status word (accepted, bad checksum, length
// mismatch or queue full); a pop gives one word per stored byte (one for
// an empty packet) with the header repeated and last on the final one, or
// one queue-empty word. Results come out of a queue read port: while empty
// is low the oldest word is on the outputs, and pop high at an edge takes it.
// A status word passes through the job queue and the result register; a
// packet stream passes the job queue, a header fetch and the result register
// and then runs at one byte per cycle while pop is held, set by the single
// payload read port. Input words are taken one per cycle, except that a header
// waits until the job queue is empty and the output side is idle (so it also
// waits behind status words still in the job queue), and trailers and pops wait
// while the four-entry job queue between the two halves is full.
// When the receiver stalls, the result register holds and the job queue fills.
// Reset clears indexes, counts, packet state and valid flags, but not the stores.
module checksum_filtered_priority_packet_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [31:0] arrival_time,
    input  logic [7:0]  dest_addr,
    input  logic [7:0]  src_addr,
    input  logic [7:0]  priority_level,
    input  logic [6:0]  payload_length,
    input  logic [7:0]  payload_byte,
    input  logic [7:0]  check_byte,
    input  logic        pop_queue,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [31:0] out_time,
    output logic [7:0]  out_dest,
    output logic [7:0]  out_src,
    output logic [7:0]  out_priority,
    output logic [6:0]  out_length,
    output logic [7:0]  out_byte,
    output logic        last
);
    import cfpq_pkg::*;

    job_t      fj, bj;
    store_wr_t wr;
    logic      fj_push, jq_full, jq_valid, jq_pop, back_busy, reads_pending;

    // Any queued or running job may still read a slot a new header could take.
    assign reads_pending = jq_valid || back_busy;

    cfpq_front #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .command(command),
        .arrival_time(arrival_time), .dest_addr(dest_addr), .src_addr(src_addr),
        .priority_level(priority_level), .payload_length(payload_length),
        .payload_byte(payload_byte), .check_byte(check_byte), .pop_queue(pop_queue),
        .reads_pending(reads_pending), .job_full(jq_full), .job_push(fj_push),
        .job(fj), .wr(wr)
    );

    cfpq_jobq u_jobq (
        .clk(clk), .rst_n(rst_n), .wr_en(fj_push), .wr_job(fj), .q_full(jq_full),
        .q_valid(jq_valid), .rd_en(jq_pop), .rd_job(bj)
    );

    cfpq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .clk(clk), .rst_n(rst_n), .wr(wr), .job_valid(jq_valid), .job(bj),
        .job_pop(jq_pop), .busy(back_busy), .empty(empty), .pop(pop),
        .status(status), .out_time(out_time), .out_dest(out_dest), .out_src(out_src),
        .out_priority(out_priority), .out_length(out_length), .out_byte(out_byte),
        .last(last)
    );

endmodule

/* rtl/cfpq_front.sv */
// Ingress side: packet assembly, checksum, queue bookkeeping and job issue.
module cfpq_front #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          command,
    input  logic [31:0]         arrival_time,
    input  logic [7:0]          dest_addr,
    input  logic [7:0]          src_addr,
    input  logic [7:0]          priority_level,
    input  logic [6:0]          payload_length,
    input  logic [7:0]          payload_byte,
    input  logic [7:0]          check_byte,
    input  logic                pop_queue,
    input  logic                reads_pending,
    input  logic                job_full,
    output logic                job_push,
    output cfpq_pkg::job_t      job,
    output cfpq_pkg::store_wr_t wr
);
    import cfpq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OW-1:0] DEPTH_O = OW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_I = IW'(QUEUE_DEPTH - 1);
    localparam logic [SLOT_W-1:0] DEPTH_S = SLOT_W'(QUEUE_DEPTH);
    localparam logic [6:0] MAXP = 7'(MAX_PAYLOAD);

    logic          open_reg, open_next;
    logic          tq_reg, tq_next;
    logic          drop_reg, drop_next;
    logic [7:0]    xor_reg, xor_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [6:0]    len_reg, len_next;
    logic [IW-1:0] head_reg [2];
    logic [IW-1:0] head_next [2];
    logic [IW-1:0] tail_reg [2];
    logic [IW-1:0] tail_next [2];
    logic [OW-1:0] occ_reg [2];
    logic [OW-1:0] occ_next [2];

    cmd_t cmd;
    logic acc;
    logic hq;

    function automatic logic [SLOT_W-1:0] slot_of(input logic q, input logic [IW-1:0] idx);
        logic [SLOT_W-1:0] base;
        base = q ? DEPTH_S : '0;
        return base + SLOT_W'(idx);
    endfunction

    function automatic logic [IW-1:0] nxt(input logic [IW-1:0] idx);
        return (idx == LAST_I) ? '0 : idx + 1'b1;
    endfunction

    assign cmd = cmd_t'(command);
    assign hq  = (priority_level != 8'd0);

    // A header may reuse a slot that an issued pop is still reading, so it
    // waits until the back end has drained every read.
    always_comb
    begin
        case (cmd)
            CMD_HEADER:  full = reads_pending;
            CMD_TRAILER: full = job_full;
            CMD_POP:     full = job_full;
            default:     full = 1'b0;
        endcase
    end

    assign acc = push && !full;

    always_comb
    begin
        open_next = open_reg;
        tq_next   = tq_reg;
        drop_next = drop_reg;
        xor_next  = xor_reg;
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        job_push  = 1'b0;
        job       = '{kind: JOB_STATUS, status: ST_EMPTY, slot: '0};
        wr        = '0;
        wr.hdr    = '{arrival_time, dest_addr, src_addr, priority_level, payload_length};
        wr.pay_byte = payload_byte;
        wr.pay_idx  = cnt_reg;
        wr.slot     = slot_of(tq_reg, tail_reg[tq_reg]);
        if (acc)
        begin
            case (cmd)
                CMD_HEADER:
                begin
                    open_next = 1'b1;
                    tq_next   = hq;
                    cnt_next  = '0;
                    len_next  = payload_length;
                    xor_next  = dest_addr ^ src_addr ^ priority_level ^ {1'b0, payload_length};
                    drop_next = (occ_reg[hq] >= DEPTH_O);
                    wr.slot   = slot_of(hq, tail_reg[hq]);
                    wr.hdr_we = !drop_next;
                end
                CMD_DATA:
                begin
                    if (open_reg)
                    begin
                        xor_next  = xor_reg ^ payload_byte;
                        wr.pay_we = !drop_reg && (cnt_reg < MAXP);
                        if (cnt_reg != 7'd127)
                            cnt_next = cnt_reg + 7'd1;
                    end
                end
                CMD_TRAILER:
                begin
                    if (open_reg)
                    begin
                        open_next = 1'b0;
                        job_push  = 1'b1;
                        if (xor_reg != check_byte)
                            job.status = ST_BAD_SUM;
                        else if (drop_reg)
                            job.status = ST_FULL;
                        else if (len_reg > MAXP || len_reg != cnt_reg)
                            job.status = ST_BAD_LEN;
                        else
                        begin
                            job.status = ST_ACCEPTED;
                            tail_next[tq_reg] = nxt(tail_reg[tq_reg]);
                            occ_next[tq_reg]  = occ_reg[tq_reg] + 1'b1;
                        end
                    end
                end
                default:
                begin
                    job_push = 1'b1;
                    if (occ_reg[pop_queue] != '0)
                    begin
                        job.kind = JOB_STREAM;
                        job.status = ST_DATA;
                        job.slot = slot_of(pop_queue, head_reg[pop_queue]);
                        head_next[pop_queue] = nxt(head_reg[pop_queue]);
                        occ_next[pop_queue]  = occ_reg[pop_queue] - 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            tq_reg   <= 1'b0;
            drop_reg <= 1'b0;
            xor_reg  <= '0;
            cnt_reg  <= '0;
            len_reg  <= '0;
            head_reg <= '{default: '0};
            tail_reg <= '{default: '0};
            occ_reg  <= '{default: '0};
        end
        else
        begin
            open_reg <= open_next;
            tq_reg   <= tq_next;
            drop_reg <= drop_next;
            xor_reg  <= xor_next;
            cnt_reg  <= cnt_next;
            len_reg  <= len_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

endmodule

/* rtl/cfpq_jobq.sv */
// Small job queue between the ingress side and the output side.
module cfpq_jobq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  cfpq_pkg::job_t wr_job,
    output logic           q_full,
    output logic           q_valid,
    input  logic           rd_en,
    output cfpq_pkg::job_t rd_job
);
    import cfpq_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW = $clog2(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign q_full  = (cnt_reg == (AW+1)'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign rd_job  = mem_reg[rp_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;

    always_comb
    begin
        wp_next  = do_wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/cfpq_back.sv */
// Output side: packet stores, pop streaming and the result register.
module cfpq_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cfpq_pkg::store_wr_t wr,
    input  logic                job_valid,
    input  cfpq_pkg::job_t      job,
    output logic                job_pop,
    output logic                busy,
    output logic                empty,
    input  logic                pop,
    output logic [2:0]          status,
    output logic [31:0]         out_time,
    output logic [7:0]          out_dest,
    output logic [7:0]          out_src,
    output logic [7:0]          out_priority,
    output logic [6:0]          out_length,
    output logic [7:0]          out_byte,
    output logic                last
);
    import cfpq_pkg::*;
    `include "checksum_filtered_priority_packet_queue_macros.svh"

    localparam int SLOTS = 2 * QUEUE_DEPTH;
    localparam int SW = $clog2(SLOTS);
    localparam int BYTES = SLOTS * MAX_PAYLOAD;
    localparam int PW = $clog2(BYTES);
    localparam logic [6:0] MAXP = 7'(MAX_PAYLOAD);

    typedef enum logic [1:0] {IDLE, FETCH, STREAM} state_t;

    header_t  hmem [SLOTS];
    logic [7:0] pmem [BYTES];

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [6:0]        k_reg, k_next;
    logic [6:0]        n_reg, n_next;
    header_t           hdr_reg, hdr_next;
    header_t           hdr_q;
    logic [7:0]        pay_q;
    logic              ovalid_reg, ovalid_next;
    status_t           st_reg, st_next;
    header_t           oh_reg, oh_next;
    logic [7:0]        ob_reg, ob_next;
    logic              ol_reg, ol_next;
    logic              out_free, load;
    logic [SW-1:0]     h_addr;
    logic [PW-1:0]     p_addr;

    assign out_free = !ovalid_reg || pop;
    assign busy     = (state_reg != IDLE);

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        k_next      = k_reg;
        n_next      = n_reg;
        hdr_next    = hdr_reg;
        ovalid_next = ovalid_reg && !pop;
        st_next     = st_reg;
        oh_next     = oh_reg;
        ob_next     = ob_reg;
        ol_next     = ol_reg;
        job_pop     = 1'b0;
        load        = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (job_valid)
                begin
                    if (job.kind == JOB_STREAM)
                    begin
                        job_pop    = 1'b1;
                        slot_next  = job.slot;
                        state_next = FETCH;
                    end
                    else if (out_free)
                    begin
                        job_pop = 1'b1;
                        load    = 1'b1;
                        st_next = job.status;
                        oh_next = '0;
                        ob_next = '0;
                        ol_next = 1'b1;
                    end
                end
            end
            FETCH:
            begin
                hdr_next   = hdr_q;
                n_next     = (hdr_q.payload_length > MAXP) ? MAXP : hdr_q.payload_length;
                k_next     = '0;
                state_next = STREAM;
            end
            STREAM:
            begin
                if (out_free)
                begin
                    load    = 1'b1;
                    st_next = ST_DATA;
                    oh_next = hdr_reg;
                    ob_next = (n_reg == '0) ? 8'd0 : pay_q;
                    ol_next = (k_reg + 7'd1 >= n_reg);
                    k_next  = k_reg + 7'd1;
                    if (ol_next)
                        state_next = IDLE;
                end
            end
            default:
                state_next = IDLE;
        endcase
        if (load)
            ovalid_next = 1'b1;
    end

    // Reads track the next byte index so read data lines up with k_reg.
    assign h_addr = (state_reg == IDLE) ? SW'(job.slot) : SW'(slot_reg);
    assign p_addr = PW'(int'(slot_next) * MAX_PAYLOAD + int'(k_next));

    always_ff @(posedge clk)
    begin
        if (wr.hdr_we)
            hmem[SW'(wr.slot)] <= wr.hdr;
        if (wr.pay_we)
            pmem[PW'(int'(wr.slot) * MAX_PAYLOAD + int'(wr.pay_idx))] <= wr.pay_byte;
        hdr_q <= hmem[h_addr];
        pay_q <= pmem[p_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            ovalid_reg <= 1'b0;
            slot_reg   <= '0;
            k_reg      <= '0;
            n_reg      <= '0;
            hdr_reg    <= '0;
            st_reg     <= ST_DATA;
            oh_reg     <= '0;
            ob_reg     <= '0;
            ol_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            slot_reg   <= slot_next;
            k_reg      <= k_next;
            n_reg      <= n_next;
            hdr_reg    <= hdr_next;
            st_reg     <= st_next;
            oh_reg     <= oh_next;
            ob_reg     <= ob_next;
            ol_reg     <= ol_next;
        end
    end

    assign empty        = !ovalid_reg;
    assign status       = st_reg;
    assign out_time     = oh_reg.arrival_time;
    assign out_dest     = oh_reg.dest_addr;
    assign out_src      = oh_reg.src_addr;
    assign out_priority = oh_reg.priority_level;
    assign out_length   = oh_reg.payload_length;
    assign out_byte     = ob_reg;
    assign last         = ol_reg;

    `CFPQ_ASSERT_SAME(a_no_overwrite, load, out_free, "result overwritten before taken")
    `CFPQ_ASSERT_NEXT(a_fetch_to_stream, state_reg == FETCH, state_reg == STREAM, "fetch stalled")
    `CFPQ_ASSERT_SAME(a_k_in_range, state_reg == STREAM && n_reg != '0, k_reg < n_reg, "byte index past length")
    `CFPQ_ASSERT_NEXT(a_last_ends_run, state_reg == STREAM && load && ol_next, state_reg == IDLE, "run did not end after last")

endmodule

/* test/tb.sv */
// Testbench of the checksum filtered priority packet queue.
module tb;
    import cfpq_pkg::*;

    localparam int QDEPTH     = 16;
    localparam int MAXPAY     = 64;
    localparam int CYCLE_CAP  = 600000;
    localparam int HOLD_LEN   = 300;
    localparam int TAIL_WAIT  = 20;

    // One word offered on the input side.
    typedef struct {
        cmd_t        cmd;
        logic [31:0] stamp;
        logic [7:0]  dest;
        logic [7:0]  src;
        logic [7:0]  prio;
        logic [6:0]  len;
        logic [7:0]  data;
        logic [7:0]  check;
        logic        popq;
    } in_word_t;

    // One word delivered on the result side.
    typedef struct {
        logic [2:0]  st;
        logic [31:0] stamp;
        logic [7:0]  dest;
        logic [7:0]  src;
        logic [7:0]  prio;
        logic [6:0]  len;
        logic [7:0]  data;
        logic        fin;
    } out_word_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  command;
    logic [31:0] arrival_time;
    logic [7:0]  dest_addr;
    logic [7:0]  src_addr;
    logic [7:0]  priority_level;
    logic [6:0]  payload_length;
    logic [7:0]  payload_byte;
    logic [7:0]  check_byte;
    logic        pop_queue;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [31:0] out_time;
    logic [7:0]  out_dest;
    logic [7:0]  out_src;
    logic [7:0]  out_priority;
    logic [6:0]  out_length;
    logic [7:0]  out_byte;
    logic        last;

    checksum_filtered_priority_packet_queue i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .command        (command),
        .arrival_time   (arrival_time),
        .dest_addr      (dest_addr),
        .src_addr       (src_addr),
        .priority_level (priority_level),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .check_byte     (check_byte),
        .pop_queue      (pop_queue),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .out_time       (out_time),
        .out_dest       (out_dest),
        .out_src        (out_src),
        .out_priority   (out_priority),
        .out_length     (out_length),
        .out_byte       (out_byte),
        .last           (last)
    );

    // Shadow copy of the block's state, kept up to date as words are taken.
    header_t    hdr_mem [2*QDEPTH];
    logic [7:0] pay_mem [2*QDEPTH][MAXPAY];
    int         head_idx [2];
    int         tail_idx [2];
    int         fill [2];
    logic [7:0] run_xor;
    int         rcvd;
    logic       tgt_q;
    logic       drop;
    logic       pkt_open;

    out_word_t  expected_words [$];

    int errors;
    int words_sent;
    int words_checked;
    int packets_stored;
    int packets_dropped;
    int empty_pops;
    int full_stalls;
    int cycles;

    // Sender pacing: bursts with gaps, or back to back when gaps are off.
    int burst_left;
    bit sender_gaps;

    // Receiver pacing.
    bit hold_req;
    int hold_left;
    int rx_mode;
    int rx_count;

    always #2 clk = ~clk;

    // Global watchdog; a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (full && push)
            full_stalls++;
        if (cycles > CYCLE_CAP)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycles, what, got, want);
        errors++;
    endtask

    // Work out the results caused by one accepted word and queue them up.
    task automatic predict_queue_word(input in_word_t w);
        out_word_t r;
        header_t   h;
        int        q;
        int        s;
        int        n;
        r = '{default: '0};
        r.fin = 1'b1;
        case (w.cmd)
            CMD_HEADER:
            begin
                q = (w.prio != 8'd0) ? 1 : 0;
                tgt_q = q[0];
                pkt_open = 1'b1;
                rcvd = 0;
                run_xor = w.dest ^ w.src ^ w.prio ^ {1'b0, w.len};
                drop = (fill[q] >= QDEPTH);
                if (!drop)
                    hdr_mem[q*QDEPTH + tail_idx[q]] =
                        '{w.stamp, w.dest, w.src, w.prio, w.len};
            end
            CMD_DATA:
            begin
                if (pkt_open)
                begin
                    run_xor ^= w.data;
                    s = int'(tgt_q)*QDEPTH + tail_idx[tgt_q];
                    if (!drop && rcvd < MAXPAY)
                        pay_mem[s][rcvd] = w.data;
                    if (rcvd < 127)
                        rcvd++;
                end
            end
            CMD_TRAILER:
            begin
                if (pkt_open)
                begin
                    pkt_open = 1'b0;
                    q = int'(tgt_q);
                    if (run_xor != w.check)
                        r.st = ST_BAD_SUM;
                    else if (drop)
                        r.st = ST_FULL;
                    else
                    begin
                        h = hdr_mem[q*QDEPTH + tail_idx[q]];
                        if (int'(h.payload_length) > MAXPAY || int'(h.payload_length) != rcvd)
                            r.st = ST_BAD_LEN;
                        else
                        begin
                            r.st = ST_ACCEPTED;
                            tail_idx[q] = (tail_idx[q] + 1) % QDEPTH;
                            fill[q]++;
                        end
                    end
                    if (r.st == ST_ACCEPTED)
                        packets_stored++;
                    else
                        packets_dropped++;
                    expected_words.push_back(r);
                end
            end
            CMD_POP:
            begin
                q = int'(w.popq);
                if (fill[q] == 0)
                begin
                    r.st = ST_EMPTY;
                    empty_pops++;
                    expected_words.push_back(r);
                end
                else
                begin
                    s = q*QDEPTH + head_idx[q];
                    h = hdr_mem[s];
                    n = (int'(h.payload_length) > MAXPAY) ? MAXPAY : int'(h.payload_length);
                    r.st    = ST_DATA;
                    r.stamp = h.arrival_time;
                    r.dest  = h.dest_addr;
                    r.src   = h.src_addr;
                    r.prio  = h.priority_level;
                    r.len   = h.payload_length;
                    if (n == 0)
                        expected_words.push_back(r);
                    for (int k = 0; k < n; k++)
                    begin
                        r.data = pay_mem[s][k];
                        r.fin  = (k == n - 1);
                        expected_words.push_back(r);
                    end
                    head_idx[q] = (head_idx[q] + 1) % QDEPTH;
                    fill[q]--;
                end
            end
        endcase
    endtask

    // Result checker: every word taken from the block must match the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, status", 32'(status), 32'd0);
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (status != want.st)
                    report_mismatch("status", 32'(status), 32'(want.st));
                if (out_time != want.stamp)
                    report_mismatch("out_time", out_time, want.stamp);
                if (out_dest != want.dest)
                    report_mismatch("out_dest", 32'(out_dest), 32'(want.dest));
                if (out_src != want.src)
                    report_mismatch("out_src", 32'(out_src), 32'(want.src));
                if (out_priority != want.prio)
                    report_mismatch("out_priority", 32'(out_priority), 32'(want.prio));
                if (out_length != want.len)
                    report_mismatch("out_length", 32'(out_length), 32'(want.len));
                if (out_byte != want.data)
                    report_mismatch("out_byte", 32'(out_byte), 32'(want.data));
                if (last != want.fin)
                    report_mismatch("last", 32'(last), 32'(want.fin));
            end
        end
    end

    // Receiver: changes pop at the falling edge. It follows a pattern that
    // switches now and then between always ready, coin flip and mostly
    // stalled. A hold request from a test makes it refuse every word for a
    // long stretch, counted here.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            pop = 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN;
            pop = 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       pop = 1'b1;
                1:       pop = 1'($urandom_range(0, 1));
                default: pop = ($urandom_range(0, 3) == 0);
            endcase
            rx_count++;
            if (rx_count % 97 == 0)
                rx_mode = $urandom_range(0, 2);
        end
    end

    // A word with every field random; callers override what matters.
    function automatic in_word_t random_word(input cmd_t c);
        in_word_t w;
        w.cmd   = c;
        w.stamp = $urandom;
        w.dest  = 8'($urandom);
        w.src   = 8'($urandom);
        w.prio  = 8'($urandom);
        w.len   = 7'($urandom);
        w.data  = 8'($urandom);
        w.check = 8'($urandom);
        w.popq  = 1'($urandom);
        return w;
    endfunction

    // Offer one word and wait until the block takes it. Called at a falling
    // edge and returns at a falling edge.
    task automatic send_word(input in_word_t w);
        if (sender_gaps && burst_left == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(0, 5))
                @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        command        = w.cmd;
        arrival_time   = w.stamp;
        dest_addr      = w.dest;
        src_addr       = w.src;
        priority_level = w.prio;
        payload_length = w.len;
        payload_byte   = w.data;
        check_byte     = w.check;
        pop_queue      = w.popq;
        push           = 1'b1;
        do
            @(posedge clk);
        while (full);
        predict_queue_word(w);
        words_sent++;
        @(negedge clk);
        push = 1'b0;
    endtask

    // Send a whole packet. Style 1 makes the stamp, addresses and bytes all
    // zero, style 2 all ones, anything else random. nbytes may differ from len
    // to cause a length mismatch; a bad sum flips the trailer's checksum.
    task automatic send_packet(input logic [7:0] prio, input logic [6:0] len,
                               input int nbytes, input bit bad_sum,
                               input int style);
        in_word_t w;
        logic [7:0] sum;
        w = random_word(CMD_HEADER);
        if (style == 1)
            {w.stamp, w.dest, w.src} = '0;
        if (style == 2)
            {w.stamp, w.dest, w.src} = '1;
        w.prio = prio;
        w.len  = len;
        sum = w.dest ^ w.src ^ prio ^ {1'b0, len};
        send_word(w);
        for (int k = 0; k < nbytes; k++)
        begin
            w = random_word(CMD_DATA);
            if (style == 1)
                w.data = 8'h00;
            if (style == 2)
                w.data = 8'hff;
            sum ^= w.data;
            send_word(w);
        end
        w = random_word(CMD_TRAILER);
        w.check = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
        send_word(w);
    endtask

    task automatic send_pop(input logic q);
        in_word_t w;
        w = random_word(CMD_POP);
        w.popq = q;
        send_word(w);
    endtask

    // Sender pause: nothing is offered until every expected word is back.
    task automatic wait_drained();
        push = 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT)
            @(negedge clk);
    endtask

    // Extremes of the header fields, both queues, zero and single byte
    // packets, each popped back out, plus a pop of an empty queue; then a bad
    // checksum, a short packet and a declared length over the maximum.
    task automatic test_directed_packets();
        send_packet(8'h00, 7'd0, 0, 1'b0, 1);
        send_packet(8'hff, 7'd1, 1, 1'b0, 2);
        send_packet(8'h01, 7'd2, 2, 1'b0, 0);
        send_pop(1'b0);
        send_pop(1'b1);
        send_pop(1'b1);
        send_pop(1'b0);
        send_packet(8'h10, 7'd1, 1, 1'b1, 0);
        send_packet(8'h00, 7'd3, 2, 1'b0, 0);
        send_packet(8'h00, 7'd65, 0, 1'b0, 0);
        wait_drained();
    endtask

    // Data and trailer words with no packet open are ignored; a header while
    // a packet is open abandons it.
    task automatic test_packet_framing();
        in_word_t w;
        send_word(random_word(CMD_DATA));
        send_word(random_word(CMD_TRAILER));
        w = random_word(CMD_HEADER);
        w.prio = 8'h00;
        send_word(w);
        send_word(random_word(CMD_DATA));
        send_packet(8'h00, 7'd1, 1, 1'b0, 0);
        send_packet(8'h80, 7'd0, 0, 1'b0, 0);
        send_pop(1'b0);
        send_pop(1'b1);
        wait_drained();
    endtask

    // Fill the high queue past its depth with zero length packets: the
    // extra packet is refused even after a pop makes room before its trailer.
    task automatic test_queue_full();
        in_word_t w;
        logic [7:0] sum;
        for (int k = 0; k < QDEPTH; k++)
            send_packet(8'($urandom_range(1, 255)), 7'd0, 0, 1'b0, 0);
        w = random_word(CMD_HEADER);
        w.prio = 8'h42;
        w.len  = 7'd0;
        sum = w.dest ^ w.src ^ w.prio;
        send_word(w);
        send_pop(1'b1);
        w = random_word(CMD_TRAILER);
        w.check = sum;
        send_word(w);
        for (int k = 0; k < QDEPTH; k++)
            send_pop(1'b1);
        wait_drained();
    endtask

    // The receiver refuses everything for a long stretch while the sender
    // keeps offering packets and pops, so the block fills and stalls.
    task automatic test_backpressure();
        hold_req = 1'b1;
        sender_gaps = 1'b0;
        for (int k = 0; k < 12; k++)
        begin
            send_packet(8'($urandom), 7'($urandom_range(0, 3)),
                        $urandom_range(0, 3), 1'b0, 0);
            send_pop(1'($urandom_range(0, 1)));
        end
        sender_gaps = 1'b1;
        wait_drained();
    endtask

    // Mostly well formed packets with random content, mixed with pops,
    // corrupted packets, abandoned packets and stray words.
    task automatic test_random_traffic(input int target);
        int         pick;
        int         n;
        logic [6:0] len;
        in_word_t   w;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 29) == 0)
                sender_gaps = ~sender_gaps;
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(7, 64))
                                              : 7'($urandom_range(0, 6));
            if ($urandom_range(0, 40) == 0)
                len = 7'd64;
            if (pick < 50)
                send_packet(($urandom_range(0, 1) ? 8'h00 : 8'($urandom)), len,
                            int'(len), 1'b0, 0);
            else if (pick < 72)
                send_pop(1'($urandom_range(0, 1)));
            else if (pick < 78)
                send_packet(8'($urandom), len, int'(len), 1'b1, 0);
            else if (pick < 84)
            begin
                n = (len == 0 || $urandom_range(0, 1)) ? int'(len) + 1 : int'(len) - 1;
                send_packet(8'($urandom), len, n, 1'b0, 0);
            end
            else if (pick < 87)
            begin
                len = 7'($urandom_range(65, 127));
                send_packet(8'($urandom), len, $urandom_range(0, 3), 1'b0, 0);
            end
            else if (pick < 93)
            begin
                // Header and a few bytes, then the packet is abandoned.
                w = random_word(CMD_HEADER);
                send_word(w);
                repeat ($urandom_range(0, 3))
                    send_word(random_word(CMD_DATA));
                send_packet(8'($urandom), len, int'(len), 1'b0, 0);
            end
            else
                send_word(random_word($urandom_range(0, 1) ? CMD_DATA : CMD_TRAILER));
        end
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        command = CMD_HEADER;
        {arrival_time, dest_addr, src_addr, priority_level} = '0;
        {payload_length, payload_byte, check_byte, pop_queue} = '0;
        head_idx = '{0, 0};
        tail_idx = '{0, 0};
        fill = '{0, 0};
        run_xor = '0;
        rcvd = 0;
        tgt_q = 1'b0;
        drop = 1'b0;
        pkt_open = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        rx_mode = 0;
        rx_count = 0;
        burst_left = 0;
        sender_gaps = 1'b1;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_packets();
        test_packet_framing();
        test_queue_full();
        test_backpressure();
        // Random traffic tops the run up to about 410 input words in all.
        test_random_traffic(410);

        $display("covered %0d input words, %0d result words checked", words_sent,
                 words_checked);
        $display("packets stored %0d, dropped %0d, empty pops %0d, input stall cycles %0d",
                 packets_stored, packets_dropped, empty_pops, full_stalls);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/cfpq_pkg.sv
rtl/cfpq_front.sv
rtl/cfpq_jobq.sv
rtl/cfpq_back.sv
rtl/checksum_filtered_priority_packet_queue.sv
test/tb.sv
